/* rtl/lodsel_pkg.sv */
// Shared types, codes and helpers for the level-of-detail selector.
// Depends on nothing; every other file in rtl/ but lodsel_ram refers to it by scoped names.
package lodsel_pkg;

   // Number of detail levels; the level field is two bits wide
   localparam int LEVELS = 4;
   // Default number of object groups
   localparam int GROUPS_DEFAULT = 256;
   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Hysteresis factor at or below this value (1.0 in Q4.12) disables it
   localparam logic [15:0] HYST_UNITY = 16'd4096;

   // Item commands
   localparam logic [1:0] CMD_EVALUATE  = 2'd0;
   localparam logic [1:0] CMD_FORCE     = 2'd1;
   localparam logic [1:0] CMD_SET_COUNT = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] CSR_LOD_ENABLE   = 3'd0;
   localparam logic [2:0] CSR_SCREEN_MODE  = 3'd1;
   localparam logic [2:0] CSR_BIAS_FACTOR  = 3'd2;
   localparam logic [2:0] CSR_HYST_FACTOR  = 3'd3;
   localparam logic [2:0] CSR_DIST_THRESH  = 3'd4;
   localparam logic [2:0] CSR_SCREEN_THRESH = 3'd5;

   // Input beat
   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  group_index;
      logic [15:0] distance;
      logic [15:0] screen_size;
      logic [2:0]  level_value;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [1:0] level;
      logic       changed;
   } rsp_type;

   // Configuration registers
   typedef struct packed {
      logic        lod_enable;
      logic        screen_size_mode;
      logic [15:0] bias_factor;
      logic [15:0] hysteresis_factor;
      logic [63:0] distance_thresholds;
      logic [63:0] screen_thresholds;
   } cfg_type;

   // Classified item passed from front to back
   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  group_index;
      logic        in_range;
      logic [1:0]  sel_level;
      logic [15:0] distance;
      logic [31:0] dist_hyst;
      logic [2:0]  level_value;
   } job_type;

   // Per-group state word
   typedef struct packed {
      logic [2:0] level_count;
      logic [1:0] current_level;
   } entry_type;

   // Pick one 16-bit threshold out of a packed set of four
   function automatic logic [15:0] thr16(input logic [63:0] packed_thr, input logic [1:0] idx);
      thr16 = packed_thr[{idx, 4'b0000} +: 16];
   endfunction

endpackage

/* rtl/lodsel_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lodsel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lodsel_fifo.sv */
// Short queue of classified items between the front and the back.
// Depends on lodsel_pkg (job_type, QUEUE_DEPTH).
module lodsel_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lodsel_pkg::job_type push_data,
   output logic               full,
   input  logic               pop,
   output lodsel_pkg::job_type pop_data,
   output logic               empty
);

   localparam int DEPTH = lodsel_pkg::QUEUE_DEPTH;
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   lodsel_pkg::job_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap and track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/lodsel_front.sv */
// Front end: classifies an incoming item and picks its raw level.
// Depends on lodsel_pkg (req_type, cfg_type, job_type, thr16, LEVELS).
module lodsel_front #(
   parameter int GROUPS = lodsel_pkg::GROUPS_DEFAULT
) (
   input  lodsel_pkg::req_type req,
   input  lodsel_pkg::cfg_type cfg,
   output lodsel_pkg::job_type job
);

   logic [31:0] biased_dist;
   logic [1:0]  sel;
   logic        hit;

   // Scale the distance by the bias factor (Q8.8), giving a Q24.8 product
   assign biased_dist = 32'(req.distance) * 32'(cfg.bias_factor);

   // Take the first threshold that matches, else the coarsest level
   always_comb begin
      logic [15:0] thr;
      sel = 2'(lodsel_pkg::LEVELS - 1);
      for (int i = lodsel_pkg::LEVELS - 2; i >= 0; i--) begin
         if (cfg.screen_size_mode) begin
            thr = lodsel_pkg::thr16(cfg.screen_thresholds, 2'(i));
            hit = req.screen_size > thr;
         end else begin
            thr = lodsel_pkg::thr16(cfg.distance_thresholds, 2'(i));
            hit = biased_dist < {8'b0, thr, 8'b0};
         end
         if (hit) begin
            sel = 2'(i);
         end
      end
   end

   // Pack the classified item; precompute distance times hysteresis factor
   always_comb begin
      job.cmd         = req.cmd;
      job.group_index = req.group_index;
      job.in_range    = (32'(req.group_index) < 32'(GROUPS));
      job.sel_level   = sel;
      job.distance    = req.distance;
      job.dist_hyst   = 32'(req.distance) * 32'(cfg.hysteresis_factor);
      job.level_value = req.level_value;
   end

endmodule

/* rtl/lodsel_back.sv */
// Back end: clears group state after reset, then does read-modify-write per item.
// Depends on lodsel_pkg and lodsel_ram.
module lodsel_back #(
   parameter int GROUPS = lodsel_pkg::GROUPS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  lodsel_pkg::cfg_type cfg,
   input  lodsel_pkg::job_type job,
   input  logic                job_valid,
   output logic                job_pop,
   output logic                clearing,
   output logic                rsp_valid,
   output lodsel_pkg::rsp_type rsp_data,
   input  logic                rsp_stall
);

   localparam int DEPTH = (GROUPS < 256) ? GROUPS : 256;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EW = $bits(lodsel_pkg::entry_type);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   lodsel_pkg::job_type job_ff, job_in;
   logic                rsp_valid_ff, rsp_valid_in;
   lodsel_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   lodsel_pkg::entry_type wr_entry, rd_entry;
   logic [EW-1:0]       rd_word;

   logic [1:0]  cur, top, nl, eval_level, force_level, after;
   logic [2:0]  cnt, eff;
   logic [15:0] thr_cur, thr_nl;
   logic [31:0] thr_h;
   logic        hyst_on, hold_coarse, hold_fine, out_free;

   lodsel_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_entry = rd_word;
   assign cur = rd_entry.current_level;
   assign cnt = rd_entry.level_count;

   // Clamp bound from the stored level count
   assign eff = (cnt > 3'(lodsel_pkg::LEVELS)) ? 3'(lodsel_pkg::LEVELS) : cnt;
   assign top = (eff == 3'd0) ? 2'd0 : 2'(eff - 3'd1);
   assign nl  = (job_ff.sel_level > top) ? top : job_ff.sel_level;

   // Hysteresis compares, cross-multiplied against Q4.12
   assign thr_cur = lodsel_pkg::thr16(cfg.distance_thresholds, cur);
   assign thr_nl  = lodsel_pkg::thr16(cfg.distance_thresholds, nl);
   assign thr_h   = 32'(thr_cur) * 32'(cfg.hysteresis_factor);
   assign hyst_on = cfg.hysteresis_factor > lodsel_pkg::HYST_UNITY;
   assign hold_coarse = {4'b0, job_ff.distance, 12'b0} < thr_h;
   assign hold_fine   = job_ff.dist_hyst > {4'b0, thr_nl, 12'b0};

   always_comb begin
      if (!cfg.lod_enable) begin
         eval_level = cur;
      end else if (hyst_on && (nl > cur) && hold_coarse) begin
         eval_level = cur;
      end else if (hyst_on && (nl < cur) && hold_fine) begin
         eval_level = cur;
      end else begin
         eval_level = nl;
      end
   end

   assign force_level = (job_ff.level_value > {1'b0, top}) ? top : job_ff.level_value[1:0];

   // Pick the new stored level by command
   always_comb begin
      unique case (job_ff.cmd)
         lodsel_pkg::CMD_EVALUATE:  after = eval_level;
         lodsel_pkg::CMD_FORCE:     after = force_level;
         lodsel_pkg::CMD_SET_COUNT: after = 2'd0;
         default:                   after = cur;
      endcase
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequence clearing, fetch and update
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      job_in       = job_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      job_pop      = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = job_ff.group_index[AW-1:0];
      wr_entry.level_count   = (job_ff.cmd == lodsel_pkg::CMD_SET_COUNT) ?
                               job_ff.level_value : cnt;
      wr_entry.current_level = after;
      rd_addr      = job_ff.group_index[AW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = clr_addr_ff;
            wr_entry = '0;
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            rd_addr = job.group_index[AW-1:0];
            if (job_valid) begin
               job_pop  = 1'b1;
               job_in   = job;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               wr_en        = job_ff.in_range;
               rsp_valid_in = 1'b1;
               if (job_ff.in_range) begin
                  rsp_data_in.level   = after;
                  rsp_data_in.changed = (after != cur);
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the item in flight and the result payload
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/lod_level_select_hysteresis.sv */
// Top level of the per-group level-of-detail selector with distance hysteresis.
// Depends on lodsel_pkg, lodsel_front, lodsel_fifo and lodsel_back.
//
//   port group | direction | handshake          | payload
//   req_*      | in        | req_valid/req_stall | lodsel_pkg::req_type
//   rsp_*      | out       | rsp_valid/rsp_stall | lodsel_pkg::rsp_type
//   csr_*      | in        | csr_wr_en           | csr_index, csr_wdata
//
// The front classifies an item in the cycle it is accepted and queues it.
// The back reads the group state RAM in its idle state and updates it in its exec
// state, held there by a stalled result; it pops no new item before the update.
// After reset a clearing pass writes min(GROUPS, 256) RAM entries, one per
// cycle; req_stall stays high during it. Configuration writes are taken anytime.
// A stalled result holds in the output register while up to two items queue.
module lod_level_select_hysteresis #(
   parameter int GROUPS = lodsel_pkg::GROUPS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lodsel_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lodsel_pkg::rsp_type rsp_data,
   input  logic                csr_wr_en,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_wdata
);

   lodsel_pkg::cfg_type cfg_ff, cfg_in;
   lodsel_pkg::job_type front_job, head_job;
   logic                q_full, q_empty, q_pop, clearing;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lodsel_pkg::CSR_LOD_ENABLE:    cfg_in.lod_enable          = csr_wdata[0];
            lodsel_pkg::CSR_SCREEN_MODE:   cfg_in.screen_size_mode    = csr_wdata[0];
            lodsel_pkg::CSR_BIAS_FACTOR:   cfg_in.bias_factor         = csr_wdata[15:0];
            lodsel_pkg::CSR_HYST_FACTOR:   cfg_in.hysteresis_factor   = csr_wdata[15:0];
            lodsel_pkg::CSR_DIST_THRESH:   cfg_in.distance_thresholds = csr_wdata;
            lodsel_pkg::CSR_SCREEN_THRESH: cfg_in.screen_thresholds   = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lod_enable          <= 1'b1;
         cfg_ff.screen_size_mode    <= 1'b0;
         cfg_ff.bias_factor         <= 16'd256;
         cfg_ff.hysteresis_factor   <= lodsel_pkg::HYST_UNITY;
         cfg_ff.distance_thresholds <= '0;
         cfg_ff.screen_thresholds   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Hold off input while the queue is full or state is being cleared
   assign req_stall = q_full || clearing;

   lodsel_front #(
      .GROUPS (GROUPS)
   ) u_front (
      .req (req_data),
      .cfg (cfg_ff),
      .job (front_job)
   );

   lodsel_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !req_stall),
      .push_data (front_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (head_job),
      .empty     (q_empty)
   );

   lodsel_back #(
      .GROUPS (GROUPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job       (head_job),
      .job_valid (!q_empty),
      .job_pop   (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

/* tb/lod_level_select_hysteresis_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for lod_level_select_hysteresis: directed and random item beats,
// with a per-group level predictor and bursty, stalling traffic on both channels.
// Depends on lodsel_pkg and the RTL in rtl/.
module lod_level_select_hysteresis_test;

   // Command code the block leaves unused
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         POOL_SIZE = 6;
   localparam int         PHASES = 8;
   localparam int         ITEMS_PER_PHASE = 175;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   lodsel_pkg::req_type req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   lodsel_pkg::rsp_type rsp_data;
   logic                csr_wr_en = 1'b0;
   logic [2:0]          csr_index = '0;
   logic [63:0]         csr_wdata = '0;

   // Mirror of the block's registers and per-group state
   lodsel_pkg::cfg_type model_cfg;
   logic [1:0]  level_mirror [256];
   logic [2:0]  count_mirror [256];
   logic [7:0]  group_pool [POOL_SIZE];

   lodsel_pkg::req_type pending_items [$];
   lodsel_pkg::rsp_type expected_levels [$];
   int          fail_count = 0;
   int          cycle_count = 0;

   // Driver and receiver pacing state
   int          burst_left = 0;
   int          gap_left = 0;
   logic        req_valid_next;
   int          stall_mode = 0;
   int          mode_left = 0;
   int          run_left = 0;
   logic        rsp_stall_next;

   lod_level_select_hysteresis DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Slice one 16-bit threshold out of a packed set
   function automatic logic [15:0] threshold_of(input logic [63:0] set, input int idx);
      return set[16*(idx & 3) +: 16];
   endfunction

   // Raw level from distance or screen size, before clamp and hysteresis
   function automatic logic [1:0] pick_level(input logic [15:0] distance_in,
                                             input logic [15:0] ssize);
      logic [63:0] biased;
      logic [63:0] limit;
      biased = 64'(distance_in) * 64'(model_cfg.bias_factor);
      for (int i = 0; i < lodsel_pkg::LEVELS - 1; i++) begin
         limit = 64'(threshold_of(model_cfg.distance_thresholds, i)) << 8;
         if (model_cfg.screen_size_mode) begin
            if (ssize > threshold_of(model_cfg.screen_thresholds, i)) return 2'(i);
         end else if (biased < limit) begin
            return 2'(i);
         end
      end
      return 2'(lodsel_pkg::LEVELS - 1);
   endfunction

   // Hold the current level while the raw distance stays inside the band
   function automatic logic [1:0] apply_hysteresis(input logic [1:0] cur, input logic [1:0] nl,
                                                   input logic [15:0] distance_in);
      logic [63:0] h;
      logic [63:0] d;
      h = 64'(model_cfg.hysteresis_factor);
      d = 64'(distance_in);
      if (h <= 64'(lodsel_pkg::HYST_UNITY)) return nl;
      if (nl > cur) begin
         if (d * 64'd4096 < 64'(threshold_of(model_cfg.distance_thresholds, cur)) * h) return cur;
      end else if (nl < cur) begin
         if (d * h > 64'(threshold_of(model_cfg.distance_thresholds, nl)) * 64'd4096) return cur;
      end
      return nl;
   endfunction

   // Advance the mirrored group state by one item and return its result
   function automatic lodsel_pkg::rsp_type update_group(input lodsel_pkg::req_type r);
      logic [1:0] before_lvl;
      logic [1:0] after_lvl;
      logic [1:0] sel;
      logic [2:0] n;
      logic [1:0] top;
      lodsel_pkg::rsp_type res;
      before_lvl = level_mirror[r.group_index];
      after_lvl = before_lvl;
      n = count_mirror[r.group_index];
      if (n > 3'(lodsel_pkg::LEVELS)) n = 3'(lodsel_pkg::LEVELS);
      top = (n == 0) ? 2'd0 : 2'(n - 1);
      case (r.cmd)
         lodsel_pkg::CMD_EVALUATE: begin
            if (model_cfg.lod_enable) begin
               sel = pick_level(r.distance, r.screen_size);
               if (sel > top) sel = top;
               after_lvl = apply_hysteresis(before_lvl, sel, r.distance);
            end
         end
         lodsel_pkg::CMD_FORCE: begin
            after_lvl = (r.level_value > {1'b0, top}) ? top : r.level_value[1:0];
         end
         lodsel_pkg::CMD_SET_COUNT: begin
            count_mirror[r.group_index] = r.level_value;
            after_lvl = 2'd0;
         end
         default: ;
      endcase
      level_mirror[r.group_index] = after_lvl;
      res.level = after_lvl;
      res.changed = (after_lvl != before_lvl);
      return res;
   endfunction

   // Pick a value within a band around a center, clipped to 16 bits
   function automatic logic [15:0] near_value(input int center);
      int off;
      int v;
      off = $urandom_range(0, center / 4 + 32);
      v = $urandom_range(0, 1) ? center + off : center - off;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   // Four random thresholds, sorted; level 0 in the low bits
   function automatic logic [63:0] sorted_thresholds(input bit ascending);
      logic [15:0] t [4];
      logic [15:0] tmp;
      int          span;
      span = $urandom_range(0, 1) ? 65535 : 4095;
      for (int i = 0; i < 4; i++) t[i] = 16'($urandom_range(0, span));
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3 - i; j++) begin
            if (ascending ? (t[j] > t[j+1]) : (t[j] < t[j+1])) begin
               tmp = t[j];
               t[j] = t[j+1];
               t[j+1] = tmp;
            end
         end
      end
      return {t[3], t[2], t[1], t[0]};
   endfunction

   // Random item, mostly evaluates on a small set of groups near the thresholds
   function automatic lodsel_pkg::req_type random_item();
      lodsel_pkg::req_type r;
      int      k;
      int      c;
      k = $urandom_range(0, 19);
      if (k < 14 || k == 19) r.cmd = lodsel_pkg::CMD_EVALUATE;
      else if (k < 16) r.cmd = lodsel_pkg::CMD_FORCE;
      else if (k < 18) r.cmd = lodsel_pkg::CMD_SET_COUNT;
      else r.cmd = CMD_UNUSED;
      if (k == 19 || $urandom_range(0, 6) == 0) r.group_index = 8'($urandom_range(0, 255));
      else r.group_index = group_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r.cmd == lodsel_pkg::CMD_SET_COUNT && $urandom_range(0, 3) != 0)
         r.level_value = 3'($urandom_range(2, 4));
      else
         r.level_value = 3'($urandom_range(0, 7));
      k = $urandom_range(0, 9);
      if (k < 3) begin
         r.distance = 16'($urandom_range(0, 65535));
      end else if (k < 7) begin
         r.distance = near_value(threshold_of(model_cfg.distance_thresholds,
                                              $urandom_range(0, 3)));
      end else if (k < 9 && model_cfg.bias_factor != 0) begin
         c = (int'(threshold_of(model_cfg.distance_thresholds, $urandom_range(0, 3))) * 256)
             / int'(model_cfg.bias_factor);
         r.distance = near_value(c);
      end else begin
         r.distance = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      k = $urandom_range(0, 9);
      if (k < 3) r.screen_size = 16'($urandom_range(0, 65535));
      else if (k < 8)
         r.screen_size = near_value(threshold_of(model_cfg.screen_thresholds,
                                                 $urandom_range(0, 3)));
      else r.screen_size = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      return r;
   endfunction

   // Write one register and mirror it; no items are in flight whenever this runs
   task automatic write_csr(input logic [2:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         lodsel_pkg::CSR_LOD_ENABLE:    model_cfg.lod_enable = value[0];
         lodsel_pkg::CSR_SCREEN_MODE:   model_cfg.screen_size_mode = value[0];
         lodsel_pkg::CSR_BIAS_FACTOR:   model_cfg.bias_factor = value[15:0];
         lodsel_pkg::CSR_HYST_FACTOR:   model_cfg.hysteresis_factor = value[15:0];
         lodsel_pkg::CSR_DIST_THRESH:   model_cfg.distance_thresholds = value;
         lodsel_pkg::CSR_SCREEN_THRESH: model_cfg.screen_thresholds = value;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_phase(input logic en, input logic mode, input logic [15:0] bias,
                            input logic [15:0] hyst, input logic [63:0] dth,
                            input logic [63:0] sth);
      write_csr(lodsel_pkg::CSR_LOD_ENABLE, 64'(en));
      write_csr(lodsel_pkg::CSR_SCREEN_MODE, 64'(mode));
      write_csr(lodsel_pkg::CSR_BIAS_FACTOR, 64'(bias));
      write_csr(lodsel_pkg::CSR_HYST_FACTOR, 64'(hyst));
      write_csr(lodsel_pkg::CSR_DIST_THRESH, dth);
      write_csr(lodsel_pkg::CSR_SCREEN_THRESH, sth);
   endtask

   task automatic queue_item(input logic [1:0] cmd, input logic [7:0] grp,
                             input logic [15:0] distance_in, input logic [15:0] ssize,
                             input logic [2:0] val);
      lodsel_pkg::req_type r;
      r.cmd = cmd;
      r.group_index = grp;
      r.distance = distance_in;
      r.screen_size = ssize;
      r.level_value = val;
      pending_items = {pending_items, r};
   endtask

   // Wait until every queued beat is sent and every result has come back
   task automatic drain();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_levels.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Driver: present queued beats in bursts, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         req_valid_next = req_valid;
         if (req_valid && !req_stall) begin
            expected_levels = {expected_levels, update_group(req_data)};
            void'(pending_items.pop_front());
            req_valid_next = 1'b0;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         if (!req_valid_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() != 0) begin
               req_data <= pending_items[0];
               req_valid_next = 1'b1;
            end
         end
         req_valid <= req_valid_next;
      end
   end

   // Monitor: check each result beat against the oldest expectation, drive stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: unexpected result level %0d changed %0d",
                        $time, rsp_data.level, rsp_data.changed);
               fail_count++;
            end else begin
               if (rsp_data.level !== expected_levels[0].level) begin
                  $display("%0t: level mismatch expected %0d actual %0d",
                           $time, expected_levels[0].level, rsp_data.level);
                  fail_count++;
               end
               if (rsp_data.changed !== expected_levels[0].changed) begin
                  $display("%0t: changed mismatch expected %0d actual %0d",
                           $time, expected_levels[0].changed, rsp_data.changed);
                  fail_count++;
               end
               void'(expected_levels.pop_front());
            end
         end
         // Switch between free flow, random stalls and stall runs
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(32, 128);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_stall_next = 1'b0;
            1: rsp_stall_next = 1'($urandom_range(0, 1));
            default: begin
               if (run_left > 0) begin
                  run_left--;
                  rsp_stall_next = rsp_stall;
               end else begin
                  rsp_stall_next = !rsp_stall;
                  run_left = $urandom_range(0, 6);
               end
            end
         endcase
         rsp_stall <= rsp_stall_next;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("lod_level_select_hysteresis regression: fail");
         $finish;
      end
   end

   initial begin
      logic [15:0] bias_v;
      logic [15:0] hyst_v;
      logic [63:0] dth;
      logic [63:0] sth;
      model_cfg = '{lod_enable: 1'b1, screen_size_mode: 1'b0, bias_factor: 16'd256,
                    hysteresis_factor: lodsel_pkg::HYST_UNITY, distance_thresholds: 64'd0,
                    screen_thresholds: 64'd0};
      for (int g = 0; g < 256; g++) begin
         level_mirror[g] = 2'd0;
         count_mirror[g] = 3'd0;
      end
      group_pool[0] = 8'd0;
      group_pool[1] = 8'd255;
      for (int i = 2; i < POOL_SIZE; i++) group_pool[i] = 8'($urandom_range(1, 254));
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: distance mode, no hysteresis
      write_csr(lodsel_pkg::CSR_DIST_THRESH, {16'd40000, 16'd3000, 16'd1000, 16'd100});
      write_csr(lodsel_pkg::CSR_SCREEN_THRESH, {16'd200, 16'd2000, 16'd8000, 16'd16384});
      queue_item(lodsel_pkg::CMD_EVALUATE, 8'd5, 16'hFFFF, 16'd0, 3'd0);  // count still zero
      queue_item(lodsel_pkg::CMD_SET_COUNT, 8'd5, 16'd0, 16'd0, 3'd4);
      queue_item(lodsel_pkg::CMD_EVALUATE, 8'd5, 16'd0, 16'd0, 3'd0);
      queue_item(lodsel_pkg::CMD_EVALUATE, 8'd5, 16'hFFFF, 16'd0, 3'd0);
      queue_item(lodsel_pkg::CMD_EVALUATE, 8'd5, 16'd500, 16'd0, 3'd0);
      queue_item(lodsel_pkg::CMD_FORCE, 8'd5, 16'd0, 16'd0, 3'd7);        // saturate to top
      queue_item(lodsel_pkg::CMD_FORCE, 8'd5, 16'd0, 16'd0, 3'd0);
      queue_item(lodsel_pkg::CMD_FORCE, 8'd9, 16'd0, 16'd0, 3'd3);        // zero count forces 0
      queue_item(lodsel_pkg::CMD_SET_COUNT, 8'd9, 16'd0, 16'd0, 3'd7);    // count above range
      queue_item(lodsel_pkg::CMD_EVALUATE, 8'd9, 16'hFFFF, 16'hFFFF, 3'd7);
      queue_item(lodsel_pkg::CMD_SET_COUNT, 8'd9, 16'd0, 16'd0, 3'd2);
      queue_item(lodsel_pkg::CMD_EVALUATE, 8'd9, 16'hFFFF, 16'd0, 3'd0);  // clamp to count-1
      queue_item(CMD_UNUSED, 8'd5, 16'hFFFF, 16'hFFFF, 3'd7);
      queue_item(lodsel_pkg::CMD_SET_COUNT, 8'd0, 16'd0, 16'd0, 3'd4);
      queue_item(lodsel_pkg::CMD_SET_COUNT, 8'd255, 16'd0, 16'd0, 3'd4);
      queue_item(lodsel_pkg::CMD_EVALUATE, 8'd255, 16'd2000, 16'd0, 3'd0);
      drain();

      // Directed: disabled evaluate leaves the level alone
      write_csr(lodsel_pkg::CSR_LOD_ENABLE, 64'd0);
      queue_item(lodsel_pkg::CMD_EVALUATE, 8'd255, 16'd0, 16'hFFFF, 3'd0);
      drain();

      // Directed: screen-size mode with hysteresis holding in both directions
      set_phase(1'b1, 1'b1, 16'd256, 16'd6144, {16'd40000, 16'd3000, 16'd1000, 16'd100},
                {16'd200, 16'd2000, 16'd8000, 16'd16384});
      queue_item(lodsel_pkg::CMD_EVALUATE, 8'd0, 16'd0, 16'hFFFF, 3'd0);
      queue_item(lodsel_pkg::CMD_EVALUATE, 8'd0, 16'd0, 16'd0, 3'd0);
      queue_item(lodsel_pkg::CMD_EVALUATE, 8'd0, 16'hFFFF, 16'd0, 3'd0);
      queue_item(lodsel_pkg::CMD_EVALUATE, 8'd0, 16'hFFFF, 16'hFFFF, 3'd0);
      queue_item(lodsel_pkg::CMD_EVALUATE, 8'd0, 16'd0, 16'hFFFF, 3'd0);
      drain();

      // Directed: zero bias in distance mode
      set_phase(1'b1, 1'b0, 16'd0, 16'd6144, {16'd40000, 16'd3000, 16'd1000, 16'd100},
                64'd0);
      queue_item(lodsel_pkg::CMD_EVALUATE, 8'd5, 16'hFFFF, 16'd0, 3'd0);
      queue_item(lodsel_pkg::CMD_EVALUATE, 8'd9, 16'hFFFF, 16'd0, 3'd0);
      drain();

      // Random phases over several register settings, extremes first
      for (int p = 0; p < PHASES; p++) begin
         dth = sorted_thresholds(1'b1);
         sth = sorted_thresholds(1'b0);
         case (p)
            0: begin
               bias_v = 16'd256;
               hyst_v = lodsel_pkg::HYST_UNITY;
            end
            1: begin
               bias_v = 16'd0;
               hyst_v = 16'd0;
               dth = 64'd0;
               sth = 64'd0;
            end
            2: begin
               bias_v = 16'hFFFF;
               hyst_v = 16'hFFFF;
               dth = '1;
               sth = '1;
            end
            default: begin
               bias_v = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(128, 512));
               hyst_v = $urandom_range(0, 1) ? 16'($urandom_range(4097, 8192))
                                             : 16'($urandom_range(0, 4096));
               if (p == 5) begin
                  dth = {$urandom, $urandom};
                  sth = {$urandom, $urandom};
               end
            end
         endcase
         set_phase((p == 4) ? 1'b0 : 1'b1, 1'(p), bias_v, hyst_v, dth, sth);
         // Give the working groups usable level counts
         for (int i = 0; i < POOL_SIZE; i++)
            queue_item(lodsel_pkg::CMD_SET_COUNT, group_pool[i], 16'($urandom), 16'($urandom),
                       ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Pause the sender midway until every result is back
            if (n == ITEMS_PER_PHASE / 2) drain();
            pending_items = {pending_items, random_item()};
         end
         drain();
      end

      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("lod_level_select_hysteresis regression: pass");
      end else begin
         $display("lod_level_select_hysteresis regression: fail");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/lodsel_pkg.sv
rtl/lodsel_ram.sv
rtl/lodsel_fifo.sv
rtl/lodsel_front.sv
rtl/lodsel_back.sv
rtl/lod_level_select_hysteresis.sv
tb/lod_level_select_hysteresis_test.sv
